[hdl/zrp_pkg.sv]
// ----------------------------------------------------------------------------
// Zigzag rail permute package
// Shared sizes, payload structs and the block descriptor used by every module but the RAM.
// ----------------------------------------------------------------------------
package zrp_pkg;

    // Block buffer and rail limits.
    localparam int MAX_LEN   = 64;
    localparam int MAX_ROWS  = 16;
    localparam int LEN_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int SUM_W     = $clog2(MAX_LEN + 2 * MAX_ROWS);
    localparam int CFG_W     = 5;
    localparam int SYM_W     = 8;

    // Two buffer banks: one fills while the other drains.
    localparam int RAM_DEPTH = 2 * MAX_LEN;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    // Descriptor queue between front and back.
    localparam int Q_DEPTH   = 2;
    localparam int QP_W      = $clog2(Q_DEPTH);
    localparam int QC_W      = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(3);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             block_end;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             out_last;
        logic             truncated;
    } t_out_item;

    // One closed block waiting to be read out.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] len;
        logic             trunc;
        logic [ROW_W-1:0] rails;
    } t_blk_desc;

    // Zero rails acts as one rail; too many rails saturate.
    function automatic logic [ROW_W-1:0] sat_rows(input logic [CFG_W-1:0] rows);
        logic [ROW_W-1:0] res;
        if (rows == '0) begin
            res = ROW_W'(1);
        end else if (int'(rows) > MAX_ROWS) begin
            res = ROW_W'(MAX_ROWS);
        end else begin
            res = ROW_W'(rows);
        end
        return res;
    endfunction

endpackage

[hdl/zrp_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module zrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/zrp_front.sv]
// ----------------------------------------------------------------------------
// Zigzag rail permute front end
// Accepts symbols into the filling bank, tracks overflow, holds the rail
// register and closes a block into a descriptor on its final symbol.
// ----------------------------------------------------------------------------
module zrp_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  zrp_pkg::t_in_item        i_data,
    // Configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [zrp_pkg::CFG_W-1:0] i_cfg_data,
    // Buffer write port
    output logic                     o_ram_we,
    output logic [zrp_pkg::ADDR_W-1:0] o_ram_waddr,
    output logic [zrp_pkg::SYM_W-1:0] o_ram_wdata,
    // Descriptor queue and drain feedback
    output logic                     o_push,
    output zrp_pkg::t_blk_desc       o_desc,
    input  logic                     i_q_full,
    input  logic                     i_done
);

    logic [zrp_pkg::CNT_W-1:0] r_fill, n_fill;
    logic                      r_ovf, n_ovf;
    logic                      r_bank;
    logic [1:0]                r_outst, n_outst;
    logic [zrp_pkg::CFG_W-1:0] r_rows;
    logic                      accept;

    // Both banks busy means nowhere to put the next symbol.
    assign o_stall     = (r_outst == 2'd2) || i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !o_stall;

    // Store the symbol while there is room, else remember the drop.
    assign o_ram_we    = accept && (int'(r_fill) < zrp_pkg::MAX_LEN);
    assign o_ram_waddr = {r_bank, r_fill[zrp_pkg::LEN_W-1:0]};
    assign o_ram_wdata = i_data.symbol;

    assign n_fill = o_ram_we ? r_fill + zrp_pkg::CNT_W'(1) : r_fill;
    assign n_ovf  = r_ovf | (accept & ~o_ram_we);

    // The final symbol closes the block.
    assign o_push       = accept && i_data.block_end;
    assign o_desc.bank  = r_bank;
    assign o_desc.len   = n_fill;
    assign o_desc.trunc = n_ovf;
    assign o_desc.rails = zrp_pkg::sat_rows(r_rows);

    // Blocks queued or draining.
    always_comb begin
        n_outst = r_outst;
        if (o_push && !i_done) begin
            n_outst = r_outst + 2'd1;
        end else if (!o_push && i_done) begin
            n_outst = r_outst - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_bank  <= 1'b0;
            r_outst <= 2'd0;
            r_rows  <= zrp_pkg::ROWS_RESET;
        end else begin
            r_outst <= n_outst;
            if (o_push) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
                r_bank <= ~r_bank;
            end else begin
                r_fill <= n_fill;
                r_ovf  <= n_ovf;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_rows <= i_cfg_data;
            end
        end
    end

    // At most two blocks are ever held, one per bank.
    a_outst_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst <= 2'd2)
        else $error("more blocks outstanding than banks");

    // The fill count never passes the buffer size.
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= zrp_pkg::MAX_LEN)
        else $error("fill count beyond buffer size");

endmodule

[hdl/zrp_queue.sv]
// ----------------------------------------------------------------------------
// Zigzag rail permute descriptor queue
// A two-entry queue of closed blocks between the front and back ends.
// ----------------------------------------------------------------------------
module zrp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  zrp_pkg::t_blk_desc i_desc,
    input  logic               i_pop,
    output zrp_pkg::t_blk_desc o_head,
    output logic               o_full,
    output logic               o_empty
);

    zrp_pkg::t_blk_desc        r_mem [zrp_pkg::Q_DEPTH];
    logic [zrp_pkg::QP_W-1:0]  r_wp;
    logic [zrp_pkg::QP_W-1:0]  r_rp;
    logic [zrp_pkg::QC_W-1:0]  r_cnt;

    assign o_full  = (int'(r_cnt) == zrp_pkg::Q_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + zrp_pkg::QP_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + zrp_pkg::QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + zrp_pkg::QC_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - zrp_pkg::QC_W'(1);
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("descriptor pushed into a full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("descriptor popped from an empty queue");

endmodule

[hdl/zrp_back.sv]
// ----------------------------------------------------------------------------
// Zigzag rail permute back end
// Walks one closed block rail by rail with a stepping position generator
// and streams the bytes out through the buffer's registered read port.
// ----------------------------------------------------------------------------
module zrp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Descriptor queue
    input  zrp_pkg::t_blk_desc        i_head,
    input  logic                      i_q_empty,
    output logic                      o_pop,
    output logic                      o_done,
    // Buffer read port
    output logic                      o_ram_re,
    output logic [zrp_pkg::ADDR_W-1:0] o_ram_raddr,
    input  logic [zrp_pkg::SYM_W-1:0] i_ram_rdata,
    // Output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output zrp_pkg::t_out_item        o_data
);

    logic                      r_busy;
    logic                      r_bank;
    logic [zrp_pkg::CNT_W-1:0] r_len;
    logic                      r_trunc;
    logic [zrp_pkg::ROW_W-1:0] r_rails;
    logic [zrp_pkg::ROW_W-1:0] r_row;
    logic [zrp_pkg::LEN_W-1:0] r_pos;
    logic                      r_phase;
    logic [zrp_pkg::CNT_W-1:0] r_cnt;
    logic                      r_out_valid;
    logic                      r_out_last;
    logic                      r_out_trunc;

    logic                      advance;
    logic                      issue;
    logic                      is_last;
    logic [zrp_pkg::SUM_W-1:0] period;
    logic [zrp_pkg::SUM_W-1:0] twice_row;
    logic [zrp_pkg::SUM_W-1:0] step;
    logic [zrp_pkg::SUM_W-1:0] pos_sum;

    // The output slot moves when empty or taken.
    assign advance = !r_out_valid || !i_stall;
    assign issue   = r_busy && advance;
    assign is_last = (r_cnt + zrp_pkg::CNT_W'(1)) == r_len;
    assign o_pop   = !r_busy && !i_q_empty;
    assign o_done  = issue && is_last;

    assign o_ram_re    = issue;
    assign o_ram_raddr = {r_bank, r_pos};

    // Distance to the next position on the same rail. Edge rails step a
    // full period; inner rails alternate between the two partial steps.
    assign period    = (zrp_pkg::SUM_W'(r_rails) << 1) - zrp_pkg::SUM_W'(2);
    assign twice_row = zrp_pkg::SUM_W'(r_row) << 1;
    always_comb begin
        if (r_rails <= zrp_pkg::ROW_W'(1)) begin
            step = zrp_pkg::SUM_W'(1);
        end else if (r_row == '0 || r_row == r_rails - zrp_pkg::ROW_W'(1)) begin
            step = period;
        end else if (!r_phase) begin
            step = period - twice_row;
        end else begin
            step = twice_row;
        end
    end
    assign pos_sum = zrp_pkg::SUM_W'(r_pos) + step;

    // Sequencer over rails and positions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (o_done) begin
                r_busy <= 1'b0;
            end
            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (advance) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Block context and walk position.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bank  <= i_head.bank;
            r_len   <= i_head.len;
            r_trunc <= i_head.trunc;
            r_rails <= i_head.rails;
            r_row   <= '0;
            r_pos   <= '0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else if (issue) begin
            r_cnt <= r_cnt + zrp_pkg::CNT_W'(1);
            if (pos_sum < zrp_pkg::SUM_W'(r_len)) begin
                r_pos   <= r_pos + zrp_pkg::LEN_W'(step);
                r_phase <= ~r_phase;
            end else begin
                r_row   <= r_row + zrp_pkg::ROW_W'(1);
                r_pos   <= zrp_pkg::LEN_W'(r_row + zrp_pkg::ROW_W'(1));
                r_phase <= 1'b0;
            end
        end
    end

    // Side fields travel beside the read data.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_last  <= is_last;
            r_out_trunc <= r_trunc;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_data.out_symbol = i_ram_rdata;
    assign o_data.out_last   = r_out_last;
    assign o_data.truncated  = r_out_trunc;

    // The walk ends exactly at the block length.
    a_cnt_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < r_len))
        else $error("walk ran past the block length");

    // Every remaining byte lies on a rail that exists.
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_row < r_rails))
        else $error("walk ran past the last rail");

endmodule

[hdl/zigzag_rail_permute.sv]
// ----------------------------------------------------------------------------
// Zigzag rail permute
// Rail fence transposition of byte blocks, emitted rail by rail.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_data (symbol, block_end)
//  output    out        o_valid / i_stall         o_data (out_symbol, out_last,
//                                                         truncated)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (num_rows)
//
//  Loading takes one symbol per cycle while the input is not stalled; a block
//  of n bytes drains through the buffer's single read port.
//  Two buffer banks let the next block load while the previous one drains;
//  the input stalls only when both banks hold closed blocks.
//  Output stalls hold the read port and the walk without losing data.
//  Reset empties the buffer, the descriptor queue and sets three rails.
// ----------------------------------------------------------------------------
module zigzag_rail_permute (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  zrp_pkg::t_in_item         i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output zrp_pkg::t_out_item        o_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [zrp_pkg::CFG_W-1:0] i_cfg_data
);

    logic                        ram_we;
    logic [zrp_pkg::ADDR_W-1:0]  ram_waddr;
    logic [zrp_pkg::SYM_W-1:0]   ram_wdata;
    logic                        ram_re;
    logic [zrp_pkg::ADDR_W-1:0]  ram_raddr;
    logic [zrp_pkg::SYM_W-1:0]   ram_rdata;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    logic                        blk_done;
    zrp_pkg::t_blk_desc          push_desc;
    zrp_pkg::t_blk_desc          head_desc;

    // Front end: loading and block closing.
    zrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_push      (q_push),
        .o_desc      (push_desc),
        .i_q_full    (q_full),
        .i_done      (blk_done)
    );

    // Closed blocks waiting for the back end.
    zrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .i_pop   (q_pop),
        .o_head  (head_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Double-banked block buffer.
    zrp_ram #(
        .WIDTH (zrp_pkg::SYM_W),
        .DEPTH (zrp_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Back end: rail-order readout.
    zrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_desc),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_done      (blk_done),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

[tb/sv/zigzag_rail_permute_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zigzag rail permute testbench
// A table of directed blocks covers the rail count extremes, a full buffer
// and a rail change inside an open block. A random phase with bursty input,
// patterned output stalls and one long output hold-off follows. Every output
// transaction is checked against a predictor that runs beside the block.
// ----------------------------------------------------------------------------
module zigzag_rail_permute_tb;

    localparam int CLK_PERIOD    = 20;
    localparam int NO_CFG        = -1;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 150;
    localparam int RANDOM_ITEMS  = 25;
    localparam int CFG_FROM_BLK  = 2;
    localparam int DIR_ROWS      = 10;

    // One directed block: an optional rail write, random filler, a final symbol.
    typedef struct packed {
        int                        cfg;
        int                        fill;
        logic [zrp_pkg::SYM_W-1:0] sym;
        logic                      last;
        logic                      typed;
        zrp_pkg::t_out_item        exp;
    } t_dir_row;

    typedef enum int {RX_FREE, RX_HALF, RX_HEAVY} t_rx_mode;

    // Typed results only for single byte blocks, whose output is the byte itself.
    localparam t_dir_row DIR_TBL [DIR_ROWS] = '{
        '{NO_CFG,  0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}}, // reset rails, one byte
        '{NO_CFG,  4, 8'hA5, 1'b1, 1'b0, '0},                   // three rails, five bytes
        '{1,       3, 8'h5A, 1'b1, 1'b0, '0},                   // one rail is identity
        '{0,       3, 8'h3C, 1'b1, 1'b0, '0},                   // zero rails act as one
        '{17,     16, 8'h99, 1'b1, 1'b0, '0},                   // too many rails saturate
        '{31,      5, 8'h18, 1'b1, 1'b0, '0},                   // more rails than bytes
        '{4,      64, 8'h22, 1'b1, 1'b0, '0},                   // closing symbol dropped
        '{7,       0, 8'h44, 1'b1, 1'b1, '{8'h44, 1'b1, 1'b0}}, // flag clears after overflow
        '{2,       3, 8'h55, 1'b0, 1'b0, '0},                   // leave the block open
        '{6,       3, 8'h66, 1'b1, 1'b0, '0}                    // rails change mid-block
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    zrp_pkg::t_in_item         i_data;
    logic                      o_valid;
    logic                      i_stall;
    zrp_pkg::t_out_item        o_data;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [zrp_pkg::CFG_W-1:0] i_cfg_data;

    // Predictor state: the open block, its overflow flag and the rail setting.
    logic [zrp_pkg::SYM_W-1:0] blk_buf [zrp_pkg::MAX_LEN];
    int                        blk_fill;
    logic                      blk_dropped;
    logic [zrp_pkg::CFG_W-1:0] rail_setting;
    zrp_pkg::t_out_item        pending_bytes [$];

    int               mismatches;
    int               burst_left;
    bit               hold_req;
    bit               hold_done;

    zigzag_rail_permute dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Store one symbol; on the closing symbol queue the block read rail by rail.
    function automatic void absorb_symbol(input zrp_pkg::t_in_item it, input bit typed,
                                          input zrp_pkg::t_out_item typed_exp);
        int                 rails, period, k, rail, n, emitted, r, p;
        zrp_pkg::t_out_item res;
        if (blk_fill < zrp_pkg::MAX_LEN) begin
            blk_buf[blk_fill] = it.symbol;
            blk_fill++;
        end else begin
            blk_dropped = 1'b1;
        end
        if (!it.block_end) begin
            return;
        end
        rails = (rail_setting == '0) ? 1 : int'(rail_setting);
        if (rails > zrp_pkg::MAX_ROWS) begin
            rails = zrp_pkg::MAX_ROWS;
        end
        period  = 2 * rails - 2;
        n       = blk_fill;
        emitted = 0;
        for (r = 0; r < rails; r++) begin
            for (p = 0; p < n; p++) begin
                if (rails == 1) begin
                    rail = 0;
                end else begin
                    k    = p % period;
                    rail = (k < rails) ? k : period - k;
                end
                if (rail == r) begin
                    emitted++;
                    res.out_symbol = blk_buf[p];
                    res.out_last   = (emitted == n);
                    res.truncated  = blk_dropped;
                    if (!typed) begin
                        pending_bytes.push_back(res);
                    end
                end
            end
        end
        if (typed) begin
            pending_bytes.push_back(typed_exp);
        end
        blk_fill    = 0;
        blk_dropped = 1'b0;
    endfunction

    // Mostly legal counts, with the extremes and out-of-range values often.
    function automatic logic [zrp_pkg::CFG_W-1:0] pick_rails();
        logic [zrp_pkg::CFG_W-1:0] rows;
        case ($urandom_range(5, 0))
            0: begin
                rows = '0;
            end
            1: begin
                rows = zrp_pkg::CFG_W'(1);
            end
            2: begin
                rows = zrp_pkg::CFG_W'(zrp_pkg::MAX_ROWS);
            end
            3: begin
                rows = '1;
            end
            default: begin
                rows = zrp_pkg::CFG_W'($urandom_range(zrp_pkg::MAX_ROWS, 2));
            end
        endcase
        return rows;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one input transaction, starting a new burst after a random gap.
    task automatic send_symbol(input logic [zrp_pkg::SYM_W-1:0] sym,
                               input logic last_flag, input bit typed,
                               input zrp_pkg::t_out_item typed_exp);
        zrp_pkg::t_in_item item;
        int                gap;
        item.symbol    = sym;
        item.block_end = last_flag;
        if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall);
        absorb_symbol(item, typed, typed_exp);
    endtask

    // Stop offering and let every queued result come out, then settle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rails(input logic [zrp_pkg::CFG_W-1:0] rows);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= rows;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        rail_setting = rows;
    endtask

    // Output stall pattern, with one long hold-off once the random phase asks.
    initial begin : rx_pattern
        int       seg_len, c;
        t_rx_mode mode;
        i_stall <= 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                seg_len = $urandom_range(60, 8);
                mode    = t_rx_mode'($urandom_range(2, 0));
                for (c = 0; c < seg_len && !(hold_req && !hold_done); c++) begin
                    case (mode)
                        RX_FREE: begin
                            i_stall <= 1'b0;
                        end
                        RX_HALF: begin
                            i_stall <= ($urandom_range(1, 0) == 1);
                        end
                        default: begin
                            i_stall <= ($urandom_range(3, 0) != 0);
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Compare each output transaction with the oldest expected byte.
    always @(posedge i_clk) begin : result_check
        zrp_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t ns: expected no result, actual %h", $time, o_data);
                mismatches++;
            end else begin
                want = pending_bytes.pop_front();
                check_field("out_symbol", want.out_symbol, o_data.out_symbol);
                check_field("out_last", want.out_last, o_data.out_last);
                check_field("truncated", want.truncated, o_data.truncated);
            end
        end
    end

    initial begin : stimulus
        int       items, blk_len, cut, blk_idx, j;
        t_dir_row row;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        mismatches   = 0;
        burst_left   = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        blk_fill     = 0;
        blk_dropped  = 1'b0;
        rail_setting = zrp_pkg::ROWS_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed blocks from the table.
        foreach (DIR_TBL[i]) begin
            row = DIR_TBL[i];
            if (row.cfg != NO_CFG) begin
                write_rails(zrp_pkg::CFG_W'(row.cfg));
            end
            repeat (row.fill) send_symbol(zrp_pkg::SYM_W'($urandom), 1'b0, 1'b0, '0);
            send_symbol(row.sym, row.last, row.typed, row.exp);
        end

        // Random blocks: mostly short, a few overflow, rails change between
        // blocks and now and then inside one.
        hold_req = 1'b1;
        items    = 0;
        blk_idx  = 0;
        while (items < RANDOM_ITEMS) begin
            if (blk_idx > CFG_FROM_BLK && $urandom_range(3, 0) == 0) begin
                write_rails(pick_rails());
            end
            blk_len = ($urandom_range(11, 0) == 0) ?
                      $urandom_range(zrp_pkg::MAX_LEN + 8, zrp_pkg::MAX_LEN - 4) :
                      $urandom_range(12, 1);
            cut = 0;
            if (blk_idx > CFG_FROM_BLK && blk_len > 1 && $urandom_range(9, 0) == 0) begin
                cut = $urandom_range(blk_len - 1, 1);
            end
            for (j = 0; j < blk_len; j++) begin
                if (cut != 0 && j == cut) begin
                    write_rails(pick_rails());
                end
                send_symbol(zrp_pkg::SYM_W'($urandom), j == blk_len - 1, 1'b0, '0);
                items++;
            end
            blk_idx++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
